FILE: rtl/ldfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldfs_pkg: shared types and constants of the led display frame serializer
// Request and result payloads, frame step codes and the two command bytes.
// ----------------------------------------------------------------------------
package ldfs_pkg;

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_SEND = 1'b1;

    localparam logic [7:0] CMD_DATA = 8'h40;
    localparam logic [7:0] CMD_ADDR = 8'hc0;

    localparam int NUM_DIGITS = 4;

    // frame steps
    localparam logic [3:0] PH_START_DATA = 4'd0;
    localparam logic [3:0] PH_CMD_DATA   = 4'd1;
    localparam logic [3:0] PH_STOP_DATA  = 4'd2;
    localparam logic [3:0] PH_START_ADDR = 4'd3;
    localparam logic [3:0] PH_CMD_ADDR   = 4'd4;
    localparam logic [3:0] PH_DIGIT_0    = 4'd5;
    localparam logic [3:0] PH_DIGIT_1    = 4'd6;
    localparam logic [3:0] PH_DIGIT_2    = 4'd7;
    localparam logic [3:0] PH_DIGIT_3    = 4'd8;
    localparam logic [3:0] PH_STOP_LAST  = 4'd9;

    // step inside start, byte or stop
    localparam logic [1:0] SUB_BITS     = 2'd0;
    localparam logic [1:0] SUB_ACK_LOW  = 2'd1;
    localparam logic [1:0] SUB_ACK_HIGH = 2'd2;
    localparam logic [1:0] SUB_FIRST    = 2'd0;
    localparam logic [1:0] SUB_SECOND   = 2'd1;

    // tick inside one bit
    localparam logic [1:0] BS_CLK_LOW  = 2'd0;
    localparam logic [1:0] BS_DATA     = 2'd1;
    localparam logic [1:0] BS_CLK_HIGH = 2'd2;

    typedef struct packed {
        logic       func;
        logic [7:0] seg_0;
        logic [7:0] seg_1;
        logic [7:0] seg_2;
        logic [7:0] seg_3;
    } req_item_t;

    typedef struct packed {
        logic clk_level;
        logic dio_level;
        logic busy_res;
        logic frame_done;
    } res_item_t;

endpackage

FILE: rtl/ldfs_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldfs_req_if: request channel
// Valid/ready channel carrying one tick or send request.
// ----------------------------------------------------------------------------
interface ldfs_req_if;
    logic                valid;
    logic                ready;
    ldfs_pkg::req_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/ldfs_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldfs_res_if: result channel
// Valid/ready channel carrying pin levels and status after each request.
// ----------------------------------------------------------------------------
interface ldfs_res_if;
    logic                valid;
    logic                ready;
    ldfs_pkg::res_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/led_display_frame_serializer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_display_frame_serializer_top: two-wire led driver frame serializer
// Steps a start / command / digits / stop frame one pin step per tick request.
// ----------------------------------------------------------------------------
// usage:
//   cmd carries requests: func 0 is one timer tick, func 1 asks for a frame
//   with the four segment bytes, which are latched if the block is idle
//   result returns one item per request: clock and data pin levels after the
//   request, busy, and frame_done on the tick that ends the final stop
// timing:
//   a request is taken on a cycle where the result register is empty or is
//   being taken; its result appears in the next cycle, so one request a
//   cycle is sustained while result.ready is high, set by the result register
// reset:
//   counters and busy clear, both pins go high (bus idle), result empty
// stall:
//   while a result waits and result.ready is low, cmd.ready drops and the
//   frame state holds; nothing is lost or repeated
// ----------------------------------------------------------------------------
module led_display_frame_serializer_top (
    input  logic            clk,
    input  logic            rst_n,
    ldfs_req_if.sink        cmd,
    ldfs_res_if.source      result
);
    import ldfs_pkg::*;

    logic [3:0] phase_reg, phase_next;
    logic [1:0] sub_phase_reg, sub_phase_next;
    logic [2:0] bit_index_reg, bit_index_next;
    logic [1:0] bit_step_reg, bit_step_next;
    logic       sending_reg, sending_next;
    logic       clk_pin_reg, clk_pin_next;
    logic       dio_pin_reg, dio_pin_next;
    logic [7:0] digit_reg [NUM_DIGITS];
    logic       done_next;

    logic       out_valid_reg;
    res_item_t  out_data_reg;

    logic       accept;
    logic       latch_digits;
    logic [7:0] cur_byte;
    logic [1:0] digit_sel;

    assign cmd.ready    = !out_valid_reg || result.ready;
    assign accept       = cmd.valid && cmd.ready;
    assign latch_digits = accept && (cmd.data.func == FUNC_SEND) && !sending_reg;

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    // digit phases 5..8 map to latched bytes 0..3
    assign digit_sel = phase_reg[1:0] - 2'd1;

    always_comb
    begin
        if (phase_reg == PH_CMD_DATA)
        begin
            cur_byte = CMD_DATA;
        end
        else if (phase_reg == PH_CMD_ADDR)
        begin
            cur_byte = CMD_ADDR;
        end
        else
        begin
            cur_byte = digit_reg[digit_sel];
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        sub_phase_next = sub_phase_reg;
        bit_index_next = bit_index_reg;
        bit_step_next  = bit_step_reg;
        sending_next   = sending_reg;
        clk_pin_next   = clk_pin_reg;
        dio_pin_next   = dio_pin_reg;
        done_next      = 1'b0;

        if (cmd.data.func == FUNC_SEND)
        begin
            if (!sending_reg)
            begin
                phase_next     = PH_START_DATA;
                sub_phase_next = SUB_FIRST;
                bit_index_next = 3'd0;
                bit_step_next  = BS_CLK_LOW;
                sending_next   = 1'b1;
            end
        end
        else if (sending_reg)
        begin
            // anything unhandled abandons the frame
            phase_next     = PH_START_DATA;
            sub_phase_next = SUB_FIRST;
            bit_index_next = 3'd0;
            bit_step_next  = BS_CLK_LOW;
            sending_next   = 1'b0;

            case (phase_reg)
                PH_START_DATA, PH_START_ADDR:
                begin
                    if (sub_phase_reg == SUB_FIRST)
                    begin
                        clk_pin_next   = 1'b1;
                        dio_pin_next   = 1'b1;
                        phase_next     = phase_reg;
                        sub_phase_next = SUB_SECOND;
                        sending_next   = 1'b1;
                    end
                    else if (sub_phase_reg == SUB_SECOND)
                    begin
                        clk_pin_next = 1'b0;
                        dio_pin_next = 1'b0;
                        phase_next   = phase_reg + 4'd1;
                        sending_next = 1'b1;
                    end
                end
                PH_CMD_DATA, PH_CMD_ADDR, PH_DIGIT_0, PH_DIGIT_1, PH_DIGIT_2, PH_DIGIT_3:
                begin
                    phase_next     = phase_reg;
                    sub_phase_next = sub_phase_reg;
                    bit_index_next = bit_index_reg;
                    sending_next   = 1'b1;
                    if (sub_phase_reg == SUB_BITS)
                    begin
                        case (bit_step_reg)
                            BS_CLK_LOW:
                            begin
                                clk_pin_next  = 1'b0;
                                bit_step_next = BS_DATA;
                            end
                            BS_DATA:
                            begin
                                dio_pin_next  = cur_byte[bit_index_reg];
                                bit_step_next = BS_CLK_HIGH;
                            end
                            BS_CLK_HIGH:
                            begin
                                clk_pin_next  = 1'b1;
                                bit_step_next = BS_CLK_LOW;
                                if (bit_index_reg == 3'd7)
                                begin
                                    bit_index_next = 3'd0;
                                    sub_phase_next = SUB_ACK_LOW;
                                end
                                else
                                begin
                                    bit_index_next = bit_index_reg + 3'd1;
                                end
                            end
                            default:
                            begin
                                phase_next     = PH_START_DATA;
                                sub_phase_next = SUB_FIRST;
                                bit_index_next = 3'd0;
                                sending_next   = 1'b0;
                            end
                        endcase
                    end
                    else if (sub_phase_reg == SUB_ACK_LOW)
                    begin
                        clk_pin_next   = 1'b0;
                        sub_phase_next = SUB_ACK_HIGH;
                    end
                    else if (sub_phase_reg == SUB_ACK_HIGH)
                    begin
                        clk_pin_next   = 1'b1;
                        sub_phase_next = SUB_BITS;
                        phase_next     = phase_reg + 4'd1;
                    end
                    else
                    begin
                        phase_next     = PH_START_DATA;
                        sub_phase_next = SUB_FIRST;
                        bit_index_next = 3'd0;
                        sending_next   = 1'b0;
                    end
                end
                PH_STOP_DATA, PH_STOP_LAST:
                begin
                    if (sub_phase_reg == SUB_FIRST)
                    begin
                        clk_pin_next   = 1'b0;
                        dio_pin_next   = 1'b0;
                        phase_next     = phase_reg;
                        sub_phase_next = SUB_SECOND;
                        sending_next   = 1'b1;
                    end
                    else if (sub_phase_reg == SUB_SECOND)
                    begin
                        clk_pin_next = 1'b1;
                        dio_pin_next = 1'b1;
                        if (phase_reg == PH_STOP_LAST)
                        begin
                            done_next = 1'b1;
                        end
                        else
                        begin
                            phase_next   = phase_reg + 4'd1;
                            sending_next = 1'b1;
                        end
                    end
                end
                default:
                begin
                    sending_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START_DATA;
            sub_phase_reg <= SUB_FIRST;
            bit_index_reg <= 3'd0;
            bit_step_reg  <= BS_CLK_LOW;
            sending_reg   <= 1'b0;
            clk_pin_reg   <= 1'b1;
            dio_pin_reg   <= 1'b1;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            sub_phase_reg <= sub_phase_next;
            bit_index_reg <= bit_index_next;
            bit_step_reg  <= bit_step_next;
            sending_reg   <= sending_next;
            clk_pin_reg   <= clk_pin_next;
            dio_pin_reg   <= dio_pin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (latch_digits)
        begin
            digit_reg[0] <= cmd.data.seg_0;
            digit_reg[1] <= cmd.data.seg_1;
            digit_reg[2] <= cmd.data.seg_2;
            digit_reg[3] <= cmd.data.seg_3;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            out_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg.clk_level  <= clk_pin_next;
            out_data_reg.dio_level  <= dio_pin_next;
            out_data_reg.busy_res   <= sending_next;
            out_data_reg.frame_done <= done_next;
        end
    end

endmodule

FILE: tb/sv/ldfs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldfs_checker: pin-level predictor and result checker
// Watches the request and result channels, steps its own copy of the frame
// sequencer on every accepted request and compares each result field by field.
// ----------------------------------------------------------------------------
module ldfs_checker (
    input  logic  clk,
    input  logic  rst_n,
    ldfs_req_if   cmd,
    ldfs_res_if   result,
    output int    mismatches,
    output int    pending,
    output int    frames_sent
);
    import ldfs_pkg::*;

    // predicted serializer state
    logic [3:0] step_q;
    logic [1:0] sub_q;
    logic [2:0] bit_q;
    logic [1:0] tick_q;
    logic       busy_q;
    logic [7:0] seg_q [NUM_DIGITS];
    logic       clk_pin;
    logic       dio_pin;

    res_item_t  pin_queue [$];

    function automatic void clear_frame();
        step_q = PH_START_DATA;
        sub_q  = SUB_FIRST;
        bit_q  = '0;
        tick_q = BS_CLK_LOW;
        busy_q = 1'b0;
    endfunction

    function automatic logic [7:0] frame_byte(logic [3:0] ph);
        logic [3:0] slot;
        slot = ph - PH_DIGIT_0;
        if (ph == PH_CMD_DATA)
            return CMD_DATA;
        if (ph == PH_CMD_ADDR)
            return CMD_ADDR;
        return seg_q[slot[1:0]];
    endfunction

    // one pin step of the frame, returns 1 when the final stop completes
    function automatic logic advance_frame();
        case (step_q)
            PH_START_DATA, PH_START_ADDR:
            begin
                if (sub_q == SUB_FIRST)
                begin
                    clk_pin = 1'b1;
                    dio_pin = 1'b1;
                    sub_q   = SUB_SECOND;
                end
                else if (sub_q == SUB_SECOND)
                begin
                    clk_pin = 1'b0;
                    dio_pin = 1'b0;
                    sub_q   = SUB_FIRST;
                    step_q  = step_q + 4'd1;
                end
                else
                    clear_frame();
            end
            PH_CMD_DATA, PH_CMD_ADDR, PH_DIGIT_0, PH_DIGIT_1, PH_DIGIT_2, PH_DIGIT_3:
            begin
                if (sub_q == SUB_BITS)
                begin
                    case (tick_q)
                        BS_CLK_LOW:
                        begin
                            clk_pin = 1'b0;
                            tick_q  = BS_DATA;
                        end
                        BS_DATA:
                        begin
                            dio_pin = 1'(frame_byte(step_q) >> bit_q);
                            tick_q  = BS_CLK_HIGH;
                        end
                        BS_CLK_HIGH:
                        begin
                            clk_pin = 1'b1;
                            tick_q  = BS_CLK_LOW;
                            if (bit_q == 3'd7)
                            begin
                                bit_q = '0;
                                sub_q = SUB_ACK_LOW;
                            end
                            else
                                bit_q = bit_q + 3'd1;
                        end
                        default:
                            clear_frame();
                    endcase
                end
                else if (sub_q == SUB_ACK_LOW)
                begin
                    // acknowledge clocking, data pin keeps its level
                    clk_pin = 1'b0;
                    sub_q   = SUB_ACK_HIGH;
                end
                else if (sub_q == SUB_ACK_HIGH)
                begin
                    clk_pin = 1'b1;
                    sub_q   = SUB_BITS;
                    step_q  = step_q + 4'd1;
                end
                else
                    clear_frame();
            end
            PH_STOP_DATA, PH_STOP_LAST:
            begin
                if (sub_q == SUB_FIRST)
                begin
                    clk_pin = 1'b0;
                    dio_pin = 1'b0;
                    sub_q   = SUB_SECOND;
                end
                else if (sub_q == SUB_SECOND)
                begin
                    clk_pin = 1'b1;
                    dio_pin = 1'b1;
                    sub_q   = SUB_FIRST;
                    if (step_q == PH_STOP_LAST)
                    begin
                        clear_frame();
                        return 1'b1;
                    end
                    step_q = step_q + 4'd1;
                end
                else
                    clear_frame();
            end
            default:
                clear_frame();
        endcase
        return 1'b0;
    endfunction

    function automatic res_item_t predict_pins(req_item_t item);
        res_item_t r;
        logic      fin;
        fin = 1'b0;
        if (item.func == FUNC_SEND)
        begin
            // a request while busy is dropped without a step
            if (!busy_q)
            begin
                seg_q[0] = item.seg_0;
                seg_q[1] = item.seg_1;
                seg_q[2] = item.seg_2;
                seg_q[3] = item.seg_3;
                clear_frame();
                busy_q = 1'b1;
            end
        end
        else if (busy_q)
            fin = advance_frame();
        r.clk_level  = clk_pin;
        r.dio_level  = dio_pin;
        r.busy_res   = busy_q;
        r.frame_done = fin;
        return r;
    endfunction

    task automatic compare_field(string name, logic want, logic got);
        if (got !== want)
        begin
            $error("%s: expected %0b, got %0b", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_item_t want;
        if (!rst_n)
        begin
            clear_frame();
            for (int i = 0; i < NUM_DIGITS; i++)
                seg_q[i] = '0;
            clk_pin     = 1'b1;
            dio_pin     = 1'b1;
            pin_queue.delete();
            mismatches  = 0;
            pending     = 0;
            frames_sent = 0;
        end
        else
        begin
            if (cmd.valid && cmd.ready)
            begin
                want = predict_pins(cmd.data);
                if (want.frame_done)
                    frames_sent++;
                pin_queue.push_back(want);
            end
            if (result.valid && result.ready)
            begin
                if (pin_queue.size() == 0)
                begin
                    $error("result with no request outstanding");
                    mismatches++;
                end
                else
                begin
                    want = pin_queue.pop_front();
                    compare_field("clk_level", want.clk_level, result.data.clk_level);
                    compare_field("dio_level", want.dio_level, result.data.dio_level);
                    compare_field("busy_res", want.busy_res, result.data.busy_res);
                    compare_field("frame_done", want.frame_done, result.data.frame_done);
                end
            end
            pending = pin_queue.size();
        end
    end

endmodule

FILE: tb/sv/tb_led_display_frame_serializer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_led_display_frame_serializer_top: frame serializer testbench
// Drives tick and send requests with random gaps and result stalls: a few
// directed items first, then mostly complete frames with random segment
// bytes, mixed with noise and cut-short frames. Checking is in ldfs_checker.
// ----------------------------------------------------------------------------
module tb_led_display_frame_serializer_top;
    import ldfs_pkg::*;

    localparam int ITEM_TARGET = 1450;
    localparam int FRAME_TICKS = 164;
    localparam int CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;

    ldfs_req_if req_ch ();
    ldfs_res_if res_ch ();

    int  mismatches;
    int  pending;
    int  frames_sent;
    int  req_total;
    int  send_total;
    int  cycle_count;
    bit  send_calm;
    bit  recv_calm;

    led_display_frame_serializer_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (req_ch),
        .result (res_ch)
    );

    ldfs_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (req_ch),
        .result      (res_ch),
        .mismatches  (mismatches),
        .pending     (pending),
        .frames_sent (frames_sent)
    );

    initial
        clk = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int pick_wait(bit calm);
        return calm ? 0 : int'($urandom_range(0, 17));
    endfunction

    function automatic logic [7:0] random_seg();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0)
            return 8'h00;
        if (sel == 1)
            return 8'hff;
        return 8'($urandom);
    endfunction

    task automatic push_request(logic func, logic [7:0] s0, logic [7:0] s1,
                                logic [7:0] s2, logic [7:0] s3);
        req_item_t item;
        int        gap;
        item.func  = func;
        item.seg_0 = s0;
        item.seg_1 = s1;
        item.seg_2 = s2;
        item.seg_3 = s3;
        if ($urandom_range(0, 63) == 0)
            send_calm = !send_calm;
        gap = pick_wait(send_calm);
        @(negedge clk);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= item;
        do
            @(posedge clk);
        while (!(req_ch.valid && req_ch.ready));
        req_total++;
        if (func == FUNC_SEND)
            send_total++;
    endtask

    task automatic push_random(logic func);
        push_request(func, random_seg(), random_seg(), random_seg(), random_seg());
    endtask

    // hold off the sender until every result is back
    task automatic drain_results();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
    endtask

    // one frame request followed by enough ticks to finish it, with stray
    // requests mixed in; now and then the frame is cut short
    task automatic run_frame();
        int ticks;
        push_random(FUNC_SEND);
        ticks = FRAME_TICKS + $urandom_range(0, 8);
        if ($urandom_range(0, 9) == 0)
            ticks = $urandom_range(1, FRAME_TICKS - 1);
        for (int i = 0; i < ticks; i++)
        begin
            if ($urandom_range(0, 99) < 3)
                push_random(FUNC_SEND);
            else
                push_random(FUNC_TICK);
        end
    endtask

    // receiver: random stall after every result
    initial
    begin
        int stall;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        res_ch.ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (res_ch.valid && res_ch.ready)
            begin
                if ($urandom_range(0, 63) == 0)
                    recv_calm = !recv_calm;
                stall = pick_wait(recv_calm);
                if (stall > 0)
                begin
                    @(negedge clk);
                    res_ch.ready <= 1'b0;
                    repeat (stall) @(negedge clk);
                    res_ch.ready <= 1'b1;
                end
            end
        end
    end

    initial
    begin
        int choice;
        int burst;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        rst_n        = 1'b0;
        req_total    = 0;
        send_total   = 0;
        cycle_count  = 0;
        send_calm    = 1'b0;
        recv_calm    = 1'b1;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // ticks while idle, segment fields ignored
        push_request(FUNC_TICK, 8'hff, 8'hff, 8'hff, 8'hff);
        push_request(FUNC_TICK, 8'h00, 8'h00, 8'h00, 8'h00);
        push_request(FUNC_SEND, 8'h00, 8'hff, 8'ha5, 8'h5a);
        // request while busy must not replace the latched bytes
        push_request(FUNC_SEND, 8'hff, 8'h00, 8'h5a, 8'ha5);
        for (int i = 0; i < 18; i++)
            push_request(FUNC_TICK, 8'h00, 8'h00, 8'h00, 8'h00);
        drain_results();

        while (req_total < ITEM_TARGET)
        begin
            choice = $urandom_range(0, 99);
            if (choice < 85)
                run_frame();
            else
            begin
                burst = $urandom_range(5, 30);
                for (int i = 0; i < burst; i++)
                    push_random(logic'($urandom_range(0, 1)));
            end
            if ($urandom_range(0, 9) == 0)
                drain_results();
        end

        drain_results();
        repeat (8) @(posedge clk);

        $display("covered %0d requests (%0d send requests), %0d frames completed",
                 req_total, send_total, frames_sent);
        $display("random gaps 0..17 on both sides, stray and cut-short frames included");
        if (mismatches == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
